// ===== sv/bq_pkg.sv =====
// Shared types, constants and the control program of the biquad cascade.
// Used by bq_dp and cascaded_biquad_iir_filter; depends on nothing else.
`default_nettype none

package bq_pkg;

  localparam int DATA_W           = 32;  // section output word, 8 fraction bits
  localparam int OUT_FRAC         = 8;
  localparam int COEF_INT_BITS    = 3;
  localparam int SLOTS            = 5;
  localparam int IDX_W            = 6;
  localparam int REQ_W            = 2;
  localparam int CNT_W            = 4;
  localparam int MAX_SECTIONS_DEF = 8;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_FILTER = 2'd0,
    REQ_COEF   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } slot_e;

  typedef enum logic [1:0] {
    SRC_HIST = 2'd0,
    SRC_XA   = 2'd1,
    SRC_XB   = 2'd2,
    SRC_XC   = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_LOADN = 2'd1,
    ACC_ADD   = 2'd2,
    ACC_SUB   = 2'd3
  } acc_e;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_LOOP = 2'd1,
    SEQ_DONE = 2'd2
  } seq_e;

  // One control word of the program.
  typedef struct packed {
    logic  coef_rd;
    slot_e slot;
    logic  hist_rd;
    logic  hist_hi;   // 0 reads y1, 1 reads y2 of the section
    logic  mul_en;
    src_e  mul_src;
    acc_e  acc_op;
    logic  ya_ld;
    logic  yb_ld;
    logic  tail;      // marked actions finish the previous section
    logic  copy_x;
    logic  round_en;
    logic  hw_y0;
    logic  hw_y1;
    seq_e  seq;
  } ctrl_t;

  // Datapath controls, already qualified by the sequencer.
  typedef struct packed {
    logic load_in;
    logic mul_en;
    src_e mul_src;
    acc_e acc_op;
    logic ya_ld;
    logic yb_ld;
    logic copy_x;
    logic round_en;
  } dp_ctrl_t;

  localparam ctrl_t CTRL_NOP = '0;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_L0  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_L1  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_L2  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_L3  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_L4  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_E0  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_E1  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_E2  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUT = 4'd8;

  // Loop steps L0..L4 start one section while the tail of the previous one
  // drains; E0..E2 drain the last section and OUT writes back and delivers.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = CTRL_NOP;
    case (step)
      STEP_L0: begin
        c.coef_rd = 1'b1;  c.slot = SLOT_A1;
        c.hist_rd = 1'b1;  c.hist_hi = 1'b0;
        c.mul_en  = 1'b1;  c.mul_src = SRC_XA;
        c.acc_op  = ACC_ADD;
        c.tail    = 1'b1;  c.copy_x = 1'b1;  c.hw_y1 = 1'b1;
      end
      STEP_L1: begin
        c.coef_rd = 1'b1;  c.slot = SLOT_A2;
        c.hist_rd = 1'b1;  c.hist_hi = 1'b1;
        c.mul_en  = 1'b1;  c.mul_src = SRC_HIST;
        c.acc_op  = ACC_ADD;
        c.ya_ld   = 1'b1;
      end
      STEP_L2: begin
        c.coef_rd = 1'b1;  c.slot = SLOT_B1;
        c.mul_en  = 1'b1;  c.mul_src = SRC_HIST;
        c.acc_op  = ACC_LOADN;
        c.yb_ld   = 1'b1;
        c.tail    = 1'b1;  c.round_en = 1'b1;
      end
      STEP_L3: begin
        c.coef_rd = 1'b1;  c.slot = SLOT_B2;
        c.mul_en  = 1'b1;  c.mul_src = SRC_XB;
        c.acc_op  = ACC_SUB;
        c.tail    = 1'b1;  c.hw_y0 = 1'b1;
      end
      STEP_L4: begin
        c.coef_rd = 1'b1;  c.slot = SLOT_B0;
        c.mul_en  = 1'b1;  c.mul_src = SRC_XC;
        c.acc_op  = ACC_ADD;
        c.seq     = SEQ_LOOP;
      end
      STEP_E0: begin
        c.mul_en  = 1'b1;  c.mul_src = SRC_XA;
        c.acc_op  = ACC_ADD;
        c.hw_y1   = 1'b1;
      end
      STEP_E1: begin
        c.acc_op  = ACC_ADD;
      end
      STEP_E2: begin
        c.round_en = 1'b1;
      end
      STEP_OUT: begin
        c.hw_y0   = 1'b1;
        c.seq     = SEQ_DONE;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bq_dp.sv =====
// Biquad datapath: one multiplier, exact accumulator, rounding and saturation.
// Driven by dp_ctrl_t words from the sequencer; depends on bq_pkg.
`default_nettype none

module bq_dp
  import bq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire dp_ctrl_t                       ctrl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x1_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x2_i,
  input  wire logic        [COEF_WIDTH-1:0]   coef_i,
  input  wire logic        [DATA_W-1:0]       hist_i,
  output logic             [DATA_W-1:0]       xa_o,
  output logic             [DATA_W-1:0]       ya_o,
  output logic             [SAMPLE_WIDTH-1:0] sample_o,
  output logic                                clip_o
);

  localparam int PW   = COEF_WIDTH + DATA_W;
  localparam int AW   = PW + 3;
  localparam int FRAC = COEF_WIDTH - 1 - COEF_INT_BITS;
  localparam int FW   = DATA_W + 1;

  localparam logic signed [AW-1:0] HALF  = AW'(1) <<< (FRAC - 1);
  localparam logic signed [AW-1:0] Y_MAX = (AW'(1) <<< (DATA_W - 1)) - AW'(1);
  localparam logic signed [AW-1:0] Y_MIN = -(AW'(1) <<< (DATA_W - 1));
  localparam logic signed [FW-1:0] F_HALF = FW'(1) <<< (OUT_FRAC - 1);
  localparam logic signed [FW-1:0] S_MAX = (FW'(1) <<< (SAMPLE_WIDTH - 1)) - FW'(1);
  localparam logic signed [FW-1:0] S_MIN = -(FW'(1) <<< (SAMPLE_WIDTH - 1));

  logic signed [DATA_W-1:0] xa_q, xb_q, xc_q, ya_q, yb_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [AW-1:0]     acc_q, acc_d;
  logic                     clip_q;

  logic signed [DATA_W-1:0] op;
  logic signed [AW-1:0]     rnd, ysh;
  logic signed [DATA_W-1:0] ysat;
  logic                     ysat_hit;
  logic signed [FW-1:0]     fsum, fsh;
  logic                     fsat_hit;

  always_comb begin
    case (ctrl_i.mul_src)
      SRC_HIST: op = hist_i;
      SRC_XA:   op = xa_q;
      SRC_XB:   op = xb_q;
      SRC_XC:   op = xc_q;
      default:  op = xa_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOADN: acc_d = -AW'(prod_q);
      ACC_ADD:   acc_d = acc_q + AW'(prod_q);
      ACC_SUB:   acc_d = acc_q - AW'(prod_q);
      default:   acc_d = acc_q;
    endcase
  end

  // Round half up to 8 fraction bits, then clamp to the 32-bit section word.
  always_comb begin
    rnd      = acc_q + HALF;
    ysh      = rnd >>> FRAC;
    ysat_hit = (ysh > Y_MAX) || (ysh < Y_MIN);
    if (ysh > Y_MAX) begin
      ysat = DATA_W'(Y_MAX);
    end else if (ysh < Y_MIN) begin
      ysat = DATA_W'(Y_MIN);
    end else begin
      ysat = ysh[DATA_W-1:0];
    end
  end

  // Final integer sample from the last section output held in xa.
  always_comb begin
    fsum     = FW'(xa_q) + F_HALF;
    fsh      = fsum >>> OUT_FRAC;
    fsat_hit = (fsh > S_MAX) || (fsh < S_MIN);
    if (fsh > S_MAX) begin
      sample_o = SAMPLE_WIDTH'(S_MAX);
    end else if (fsh < S_MIN) begin
      sample_o = SAMPLE_WIDTH'(S_MIN);
    end else begin
      sample_o = fsh[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= $signed(coef_i) * op;
    end
    acc_q <= acc_d;
    if (ctrl_i.load_in) begin
      xa_q   <= DATA_W'(x_i) <<< OUT_FRAC;
      xb_q   <= DATA_W'(x1_i) <<< OUT_FRAC;
      xc_q   <= DATA_W'(x2_i) <<< OUT_FRAC;
      clip_q <= 1'b0;
    end else begin
      if (ctrl_i.copy_x) begin
        xb_q <= ya_q;
        xc_q <= yb_q;
      end
      if (ctrl_i.round_en) begin
        xa_q   <= ysat;
        clip_q <= clip_q | ysat_hit;
      end
    end
    if (ctrl_i.ya_ld) begin
      ya_q <= hist_i;
    end
    if (ctrl_i.yb_ld) begin
      yb_q <= hist_i;
    end
  end

  assign xa_o   = xa_q;
  assign ya_o   = ya_q;
  assign clip_o = clip_q | fsat_hit;

endmodule

`default_nettype wire

// ===== sv/cascaded_biquad_iir_filter.sv =====
// Cascaded direct-form-I biquad equalizer: sequencer, stores and top ports.
// Depends on bq_pkg, bq_ram and bq_dp.
//
// Input stream (s_axis): tuser carries the request kind; tdata carries the
// sample, the coefficient index and the coefficient value. A coefficient
// beat writes one Q3.28 coefficient, a clear beat zeroes all input and
// section histories; neither gives an output beat or sets busy. A filter
// beat runs the active sections and gives one output beat (m_axis) holding
// the rounded, saturated sample in tdata and the clip flag in tuser.
// Each section runs through the shared multiplier in five steps, and the
// next section starts as soon as the last one's coefficient reads are out.
// A new beat is accepted only after the filter beat has finished
// (s_axis_tready is low while busy). The shared multiplier and the
// single read port of the coefficient store set the length of a beat.
// The section count is written through cfg_we_i/cfg_wdata_i; the user
// must do so only while idle, and the block itself does not enforce it.
// Reset clears coefficients and histories (valid bits) and sets one section.
// If the receiver stalls, the finished sample waits in the output register;
// a later filter beat is accepted but holds in its last step until the
// output register frees up.
`default_nettype none

module cascaded_biquad_iir_filter
  import bq_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // cfg_wdata_i: section_count
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: sample_in, coef_index, coef_value, zero pad
  input  wire logic [((SAMPLE_WIDTH+IDX_W+COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type
  input  wire logic [REQ_W-1:0] s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // tdata: sample_out, zero pad
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // tuser: clipped
  output logic [0:0]            m_axis_tuser
);

  localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int COEF_DEPTH = MAX_SECTIONS * SLOTS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int HIST_DEPTH = 2 * MAX_SECTIONS;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int OUT_TD_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

  // Input fields
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic        [IDX_W-1:0]        in_idx;
  logic        [COEF_WIDTH-1:0]   in_coef;
  logic                           in_beat;

  assign in_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign in_idx    = s_axis_tdata[SAMPLE_WIDTH+IDX_W-1:SAMPLE_WIDTH];
  assign in_coef   = s_axis_tdata[SAMPLE_WIDTH+IDX_W+COEF_WIDTH-1:SAMPLE_WIDTH+IDX_W];
  assign in_beat   = s_axis_tvalid && s_axis_tready;

  // Control state
  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [SEC_W-1:0]  sec_q, last_sec;
  logic [CNT_W-1:0]  cnt_q;
  logic signed [SAMPLE_WIDTH-1:0] x1_q, x2_q;
  logic [COEF_DEPTH-1:0] coef_vld_q;
  logic [HIST_DEPTH-1:0] hist_vld_q;
  logic coef_rv_q, hist_rv_q;
  logic m_valid_q;
  logic [SAMPLE_WIDTH-1:0] m_sample_q;
  logic m_clip_q;

  ctrl_t    ctrl;
  dp_ctrl_t dp_ctrl;
  logic     act;       // tail actions allowed (a previous section exists)
  logic     out_stall;
  logic     out_load;

  logic            coef_we, coef_re;
  logic [CA_W-1:0] coef_waddr, coef_raddr;
  logic [COEF_WIDTH-1:0] coef_rdata, coef_op;
  logic            hist_we, hist_re;
  logic [HA_W-1:0] hist_waddr, hist_raddr;
  logic [DATA_W-1:0] hist_wdata, hist_rdata, hist_op;
  logic [SEC_W-1:0] hsec;
  logic [DATA_W-1:0] xa, ya;
  logic [SAMPLE_WIDTH-1:0] dp_sample;
  logic dp_clip;

  // Clamp the section count: zero acts as one, anything above the maximum
  // acts as the maximum.
  always_comb begin
    if (cnt_q == '0) begin
      last_sec = '0;
    end else if (32'(cnt_q) > 32'(MAX_SECTIONS)) begin
      last_sec = SEC_W'(MAX_SECTIONS - 1);
    end else begin
      last_sec = SEC_W'(cnt_q - CNT_W'(1));
    end
  end

  assign ctrl      = busy_q ? ucode(step_q) : CTRL_NOP;
  assign act       = !ctrl.tail || (sec_q != '0);
  assign out_stall = m_valid_q && !m_axis_tready;
  assign out_load  = (ctrl.seq == SEQ_DONE) && !out_stall;
  assign s_axis_tready = !busy_q;

  always_comb begin
    dp_ctrl          = '0;
    dp_ctrl.load_in  = in_beat && (s_axis_tuser == REQ_FILTER);
    dp_ctrl.mul_en   = ctrl.mul_en;
    dp_ctrl.mul_src  = ctrl.mul_src;
    dp_ctrl.acc_op   = ctrl.acc_op;
    dp_ctrl.ya_ld    = ctrl.ya_ld;
    dp_ctrl.yb_ld    = ctrl.yb_ld;
    dp_ctrl.copy_x   = ctrl.copy_x && act;
    dp_ctrl.round_en = ctrl.round_en && act;
  end

  // Coefficient store
  assign coef_we    = in_beat && (s_axis_tuser == REQ_COEF)
                      && (32'(in_idx) < 32'(COEF_DEPTH));
  assign coef_waddr = CA_W'(in_idx);
  assign coef_re    = ctrl.coef_rd;
  assign coef_raddr = CA_W'(sec_q) * CA_W'(SLOTS) + CA_W'(ctrl.slot);
  assign coef_op    = coef_rv_q ? coef_rdata : '0;

  bq_ram #(
    .WIDTH(COEF_WIDTH),
    .DEPTH(COEF_DEPTH)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(in_coef),
    .re_i   (coef_re),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  // Section history store: y1 at even, y2 at odd addresses
  assign hsec       = ctrl.tail ? (sec_q - SEC_W'(1)) : sec_q;
  assign hist_we    = (ctrl.hw_y0 || ctrl.hw_y1) && act;
  assign hist_waddr = HA_W'({hsec, ctrl.hw_y1});
  assign hist_wdata = ctrl.hw_y1 ? ya : xa;
  assign hist_re    = ctrl.hist_rd;
  assign hist_raddr = HA_W'({sec_q, ctrl.hist_hi});
  assign hist_op    = hist_rv_q ? hist_rdata : '0;

  bq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .re_i   (hist_re),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  bq_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_dp (
    .clk_i   (clk_i),
    .ctrl_i  (dp_ctrl),
    .x_i     (in_sample),
    .x1_i    (x1_q),
    .x2_i    (x2_q),
    .coef_i  (coef_op),
    .hist_i  (hist_op),
    .xa_o    (xa),
    .ya_o    (ya),
    .sample_o(dp_sample),
    .clip_o  (dp_clip)
  );

  // Sequencer, stores' valid bits, input history, config register, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      step_q     <= STEP_L0;
      sec_q      <= '0;
      cnt_q      <= CNT_W'(1);
      x1_q       <= '0;
      x2_q       <= '0;
      coef_vld_q <= '0;
      hist_vld_q <= '0;
      coef_rv_q  <= 1'b0;
      hist_rv_q  <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (coef_re) begin
        coef_rv_q <= coef_vld_q[coef_raddr];
      end
      if (hist_re) begin
        hist_rv_q <= hist_vld_q[hist_raddr];
      end
      if (in_beat && (s_axis_tuser == REQ_CLEAR)) begin
        hist_vld_q <= '0;
        x1_q       <= '0;
        x2_q       <= '0;
      end else if (hist_we) begin
        hist_vld_q[hist_waddr] <= 1'b1;
      end
      if (in_beat && (s_axis_tuser == REQ_FILTER)) begin
        busy_q <= 1'b1;
        step_q <= STEP_L0;
        sec_q  <= '0;
        x1_q   <= in_sample;
        x2_q   <= x1_q;
      end else if (busy_q) begin
        case (ctrl.seq)
          SEQ_NEXT: step_q <= step_q + STEP_W'(1);
          SEQ_LOOP: begin
            if (sec_q == last_sec) begin
              step_q <= STEP_E0;
            end else begin
              step_q <= STEP_L0;
              sec_q  <= sec_q + SEC_W'(1);
            end
          end
          SEQ_DONE: begin
            // hold here while the output register is full and the receiver stalls
            if (!out_stall) begin
              busy_q <= 1'b0;
            end
          end
          default: step_q <= STEP_L0;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_sample_q <= dp_sample;
      m_clip_q   <= dp_clip;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TD_W'(m_sample_q);
  assign m_axis_tuser  = m_clip_q;

  a_sec_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (sec_q <= last_sec))
    else $error("section counter beyond the active cascade");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= STEP_OUT))
    else $error("step counter outside the program");

  a_hist_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_we && hist_re) |-> (hist_waddr != hist_raddr))
    else $error("history write and read hit the same entry");

  a_coef_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_we |-> !busy_q)
    else $error("coefficient write while a sample is in flight");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (ctrl.seq == SEQ_DONE) && !out_stall) |=> (m_axis_tvalid && !busy_q))
    else $error("finished sample not presented");

endmodule

`default_nettype wire
